/* rtl/srq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srq_pkg
// Types, constants and helpers shared by the sorted request queue.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int LEVEL_BITS  = 5;
  localparam int TIME_BITS   = 16;

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_PEEK   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Sort key codes
  localparam logic [1:0] KEY_TIME     = 2'd0;
  localparam logic [1:0] KEY_DST_UP   = 2'd1;
  localparam logic [1:0] KEY_DST_DOWN = 2'd2;

  typedef struct packed {
    logic [1:0]            func;
    logic [TIME_BITS-1:0]  arrival_time;
    logic [LEVEL_BITS-1:0] from_level;
    logic [LEVEL_BITS-1:0] to_level;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [TIME_BITS-1:0]  head_time;
    logic [LEVEL_BITS-1:0] head_from;
    logic [LEVEL_BITS-1:0] head_to;
    logic [CNT_W-1:0]      occupancy;
    logic                  is_empty;
  } rsp_t;

  // One stored request record
  typedef struct packed {
    logic [TIME_BITS-1:0]  t;
    logic [LEVEL_BITS-1:0] src;
    logic [LEVEL_BITS-1:0] dst;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_HEAD,
    ST_RESP
  } state_t;

  // True when key(a) sorts strictly ahead of key(b)
  function automatic logic key_less(logic [1:0] key, rec_t a, rec_t b);
    logic res;
    case (key)
      KEY_TIME:     res = (a.t < b.t);
      KEY_DST_UP:   res = (a.dst < b.dst);
      KEY_DST_DOWN: res = (a.dst > b.dst);
      default:      res = 1'b0;
    endcase
    return res;
  endfunction

  // Step a ring address forward by one
  function automatic logic [ADDR_W-1:0] next_addr(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] res;
    if (a == ADDR_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = a + ADDR_W'(1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/srq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/srq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srq_ctrl
// Queue sequencer: ring pointers, sorted-insert scan over the record RAM,
// head read for pop and peek, and the result register.
// ----------------------------------------------------------------------------
module srq_ctrl
  import srq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  sort_key,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  output logic             ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [REC_W-1:0] ram_wr_data,
  output logic             ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  wire logic [REC_W-1:0] ram_rd_data
);

  state_t            state, state_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [ADDR_W-1:0] addr, addr_next;
  rec_t              carry, carry_next;
  logic              placing, placing_next;
  logic [1:0]        func, func_next;
  logic [1:0]        status, status_next;
  logic              rsp_load;
  rsp_t              rsp_next;

  logic              out_free;
  logic [ADDR_W:0]   tail_sum;
  logic [ADDR_W-1:0] tail_addr;
  rec_t              rd_rec;
  rec_t              req_rec;
  logic              take;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);
  assign rd_rec    = rec_t'(ram_rd_data);
  assign req_rec   = '{t: req.arrival_time, src: req.from_level, dst: req.to_level};
  assign take      = placing || key_less(sort_key, carry, rd_rec);

  // Slot just past the last entry
  always_comb begin
    tail_sum = (ADDR_W + 1)'(head) + (ADDR_W + 1)'(count);
    if (tail_sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (ADDR_W + 1)'(QUEUE_DEPTH);
    end
    tail_addr = tail_sum[ADDR_W-1:0];
  end

  // Next state, RAM accesses and result
  always_comb begin
    state_next   = state;
    head_next    = head;
    count_next   = count;
    idx_next     = idx;
    addr_next    = addr;
    carry_next   = carry;
    placing_next = placing;
    func_next    = func;
    status_next  = status;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = addr;
    ram_wr_data  = carry;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = head;
    rsp_load     = 1'b0;
    rsp_next     = '{status: ST_OK, head_time: '0, head_from: '0, head_to: '0,
                     occupancy: count, is_empty: (count == '0)};

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          func_next    = req.func;
          carry_next   = req_rec;
          placing_next = 1'b0;
          idx_next     = '0;
          addr_next    = head;
          status_next  = ST_OK;
          case (req.func)
            FUNC_INSERT: begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                status_next = ST_FULL;
                state_next  = ST_RESP;
              end else if (count == '0) begin
                state_next = ST_TAIL;
              end else begin
                ram_rd_en  = 1'b1;
                state_next = ST_SCAN;
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
                state_next  = ST_RESP;
              end else begin
                ram_rd_en  = 1'b1;
                state_next = ST_HEAD;
              end
            end
            default: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end

      // Walk from the head; once the new record is placed, ripple entries up
      ST_SCAN: begin
        if (take) begin
          ram_wr_en    = 1'b1;
          carry_next   = rd_rec;
          placing_next = 1'b1;
        end
        if (idx + CNT_W'(1) == count) begin
          state_next = ST_TAIL;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = next_addr(addr);
          idx_next    = idx + CNT_W'(1);
          addr_next   = next_addr(addr);
        end
      end

      // Write the carried record into the free slot and commit
      ST_TAIL: begin
        ram_wr_addr = tail_addr;
        if (out_free) begin
          ram_wr_en          = 1'b1;
          count_next         = count + CNT_W'(1);
          rsp_load           = 1'b1;
          rsp_next.occupancy = count + CNT_W'(1);
          rsp_next.is_empty  = 1'b0;
          state_next         = ST_IDLE;
        end
      end

      // Return the head; a pop also drops it
      ST_HEAD: begin
        if (out_free) begin
          rsp_load           = 1'b1;
          rsp_next.head_time = rd_rec.t;
          rsp_next.head_from = rd_rec.src;
          rsp_next.head_to   = rd_rec.dst;
          if (func == FUNC_POP) begin
            head_next          = next_addr(head);
            count_next         = count - CNT_W'(1);
            rsp_next.occupancy = count - CNT_W'(1);
            rsp_next.is_empty  = (count == CNT_W'(1));
          end
          state_next = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          rsp_load        = 1'b1;
          rsp_next.status = status;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    addr    <= addr_next;
    carry   <= carry_next;
    placing <= placing_next;
    func    <= func_next;
    status  <= status_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Occupancy never passes the queue depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("srq_ctrl: occupancy beyond depth");

  // RAM is written only by the insert path
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == ST_SCAN || state == ST_TAIL))
    else $error("srq_ctrl: write outside insert");

  // A completed pop drops exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD && out_free && func == FUNC_POP)
      |=> count == $past(count) - CNT_W'(1))
    else $error("srq_ctrl: pop count mismatch");

  // A full status is reported only on a full queue
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && rsp_next.status == ST_FULL) |-> count == CNT_W'(QUEUE_DEPTH))
    else $error("srq_ctrl: full status on non-full queue");

  // Results show up only after the sequencer leaves idle
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> state != ST_IDLE)
    else $error("srq_ctrl: result loaded from idle");

endmodule
`default_nettype wire

/* rtl/sorted_request_queue_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_request_queue_top
// Bounded request queue kept in key order in a ring-addressed record RAM.
//
//   channel   dir   handshake              payload
//   req       in    req_valid / req_stall  req_t (func, time, from, to)
//   rsp       out   rsp_valid / rsp_stall  rsp_t (status, head, occupancy)
//   config    in    APB psel/penable/...   sort_key at byte address 0
//
// Insert into n held entries does one read-modify-write step per entry on the
// record RAM, then the tail write. Pop and peek accept with the head read, then
// give the result; refused and unused ones accept, then give the result.
// One item is worked on at a time; a new item is taken while a result waits.
// Reset empties the queue and sets sort_key to time ascending; no RAM pass.
// A stalled result holds in the output register; the last step waits for it.
// ----------------------------------------------------------------------------
module sorted_request_queue_top
  import srq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_SORT_KEY = 1'b0;

  logic [1:0]        sort_key;
  logic              cfg_wr;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [REC_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [REC_W-1:0]  ram_rd_data;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SORT_KEY);
  assign prdata = (paddr[2] == REG_SORT_KEY) ? 32'(sort_key) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= KEY_TIME;
    end else if (cfg_wr) begin
      sort_key <= pwdata[1:0];
    end
  end

  srq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .sort_key    (sort_key),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  srq_ram #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_records (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
`default_nettype wire
